[hdl/ufl_pkg.sv]
// ----------------------------------------------------------------------------
// ufl_pkg
// Shared types and constants of the flash loader byte parser: command and
// reply codes, register reset values and the record passed front to back.
// ----------------------------------------------------------------------------
package ufl_pkg;

	// geometry defaults
	localparam int PAGE_BYTES_DEF = 256;
	localparam int ADDR_BITS_DEF  = 22;
	localparam int FLASH_ADDR_W   = 22;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// command bytes received in idle
	localparam logic [7:0] CMD_HANDSHAKE = 8'hB5;
	localparam logic [7:0] CMD_ERASE     = 8'hB6;
	localparam logic [7:0] CMD_WRITE     = 8'hB7;
	localparam logic [7:0] CMD_JUMP      = 8'hB8;

	// reply bytes
	localparam logic [7:0] RSP_ACK        = 8'hE7;
	localparam logic [7:0] RSP_HANDSHAKE  = 8'hFB;
	localparam logic [7:0] RSP_ERASE_DONE = 8'hFE;
	localparam logic [7:0] RSP_WRITE      = 8'hFD;
	localparam logic [7:0] RSP_FAIL       = 8'h55;

	// register reset values
	localparam logic [21:0] LOW_BASE_RST  = 22'h3E8000;
	localparam logic [21:0] HIGH_BASE_RST = 22'h3EC000;
	localparam logic [15:0] SPLIT_RST     = 16'd128;

	// register indexes on the configuration port
	localparam logic [1:0] REG_LOW_BASE  = 2'd0;
	localparam logic [1:0] REG_HIGH_BASE = 2'd1;
	localparam logic [1:0] REG_SPLIT     = 2'd2;

	// input opcodes
	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_STATUS = 1'b1;

	typedef enum logic [1:0] {
		KIND_TX    = 2'd0,
		KIND_PROG  = 2'd1,
		KIND_ERASE = 2'd2,
		KIND_JUMP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EW_NONE   = 2'd0,
		EW_SECT_E = 2'd1,
		EW_SECT_D = 2'd2
	} erase_st_t;

	typedef enum logic {
		SLOT_FIRST  = 1'b0,
		SLOT_SECOND = 1'b1
	} slot_t;

	// configuration registers as seen by the front
	typedef struct packed {
		logic [21:0] low_base;
		logic [21:0] high_base;
		logic [15:0] split;
	} cfg_t;

	// one classified item: one or two results
	typedef struct packed {
		logic        two;
		kind_t       kind0;
		logic [7:0]  tx0;
		kind_t       kind1;
		logic [7:0]  tx1;
		logic [21:0] addr;
		logic [15:0] data;
		logic        hs;
	} rec_t;

endpackage

[hdl/ufl_front.sv]
// ----------------------------------------------------------------------------
// ufl_front
// Accepts items, tracks parser state (write phase, page index, erase flow,
// handshake flag) and turns each item into a record of its results.
// ----------------------------------------------------------------------------
module ufl_front #(
	parameter int PAGE_BYTES = ufl_pkg::PAGE_BYTES_DEF,
	parameter int ADDR_BITS  = ufl_pkg::ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ufl_pkg::cfg_t cfg,
	input  logic          push,
	input  logic          opcode,
	input  logic [7:0]    rx_byte,
	input  logic          erase_ok,
	input  logic          q_full,
	output logic          q_push,
	output ufl_pkg::rec_t q_rec
);
	import ufl_pkg::*;

	localparam int PH_W       = $clog2(PAGE_BYTES + 3);
	localparam int HALF       = PAGE_BYTES / 2;
	localparam int OFF_W      = 16 + $clog2(PAGE_BYTES);
	localparam int SUM_W      = ((OFF_W > FLASH_ADDR_W) ? OFF_W : FLASH_ADDR_W) + 2;
	localparam logic [PH_W-1:0] LAST_PHASE  = PH_W'(PAGE_BYTES + 2);
	localparam logic [PH_W-1:0] FIRST_DATA  = PH_W'(3);
	localparam logic [FLASH_ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= FLASH_ADDR_W) ?
		{FLASH_ADDR_W{1'b1}} : FLASH_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	logic [PH_W-1:0]         phase_q, phase_d;
	logic [15:0]             pidx_q, pidx_d;
	logic [7:0]              hold_q, hold_d;
	logic                    hs_q, hs_d;
	erase_st_t               erase_q, erase_d;
	logic [OFF_W-1:0]        off_q;
	logic [21:0]             base_sel_q;
	logic                    accept;
	logic [PH_W-1:0]         idx;
	logic [SUM_W-1:0]        sum;
	rec_t                    rec;
	logic                    has_res;

	assign accept = push && !q_full;

	// page offset and base, settled before the first data word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q      <= '0;
			base_sel_q <= '0;
		end else begin
			off_q      <= OFF_W'(OFF_W'(pidx_q) * OFF_W'(HALF));
			base_sel_q <= (pidx_q <= cfg.split) ? cfg.low_base : cfg.high_base;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pidx_q  <= '0;
			hold_q  <= '0;
			hs_q    <= 1'b0;
			erase_q <= EW_NONE;
		end else begin
			phase_q <= phase_d;
			pidx_q  <= pidx_d;
			hold_q  <= hold_d;
			hs_q    <= hs_d;
			erase_q <= erase_d;
		end
	end

	// word address of the current data byte pair
	assign idx = phase_q - FIRST_DATA;
	assign sum = SUM_W'(base_sel_q) + SUM_W'(off_q) + SUM_W'(idx[PH_W-1:1]);

	// decode and next state
	always_comb begin
		phase_d = phase_q;
		pidx_d  = pidx_q;
		hold_d  = hold_q;
		hs_d    = hs_q;
		erase_d = erase_q;
		rec     = '0;
		has_res = 1'b0;
		if (accept) begin
			if (opcode == OP_STATUS) begin
				case (erase_q)
					EW_SECT_E: begin
						has_res   = 1'b1;
						rec.two   = 1'b1;
						rec.kind0 = KIND_TX;
						rec.tx0   = erase_ok ? RSP_ACK : RSP_FAIL;
						rec.kind1 = KIND_ERASE;
						erase_d   = EW_SECT_D;
					end
					EW_SECT_D: begin
						has_res   = 1'b1;
						rec.kind0 = KIND_TX;
						rec.tx0   = erase_ok ? RSP_ERASE_DONE : RSP_FAIL;
						erase_d   = EW_NONE;
					end
					default: ;
				endcase
			end else if (erase_q != EW_NONE) begin
				// bytes ignored while an erase is pending
			end else if (phase_q == PH_W'(1)) begin
				pidx_d  = {8'd0, rx_byte};
				phase_d = PH_W'(2);
			end else if (phase_q == PH_W'(2)) begin
				pidx_d  = {pidx_q[7:0], rx_byte};
				phase_d = FIRST_DATA;
			end else if (phase_q != '0) begin
				phase_d = (phase_q >= LAST_PHASE) ? '0 : phase_q + PH_W'(1);
				if (!idx[0]) begin
					hold_d = rx_byte;
				end else begin
					has_res   = 1'b1;
					rec.kind0 = KIND_PROG;
					rec.addr  = sum[FLASH_ADDR_W-1:0] & ADDR_MASK;
					rec.data  = {hold_q, rx_byte};
				end
			end else begin
				case (rx_byte)
					CMD_HANDSHAKE: begin
						hs_d      = 1'b1;
						has_res   = 1'b1;
						rec.two   = 1'b1;
						rec.kind0 = KIND_TX;
						rec.tx0   = RSP_ACK;
						rec.kind1 = KIND_TX;
						rec.tx1   = RSP_HANDSHAKE;
					end
					CMD_ERASE: begin
						has_res   = 1'b1;
						rec.kind0 = KIND_ERASE;
						erase_d   = EW_SECT_E;
					end
					CMD_WRITE: begin
						phase_d   = PH_W'(1);
						has_res   = 1'b1;
						rec.two   = 1'b1;
						rec.kind0 = KIND_TX;
						rec.tx0   = RSP_ACK;
						rec.kind1 = KIND_TX;
						rec.tx1   = RSP_WRITE;
					end
					CMD_JUMP: begin
						has_res   = 1'b1;
						rec.two   = 1'b1;
						rec.kind0 = KIND_TX;
						rec.tx0   = RSP_ACK;
						rec.kind1 = KIND_JUMP;
					end
					default: ;
				endcase
			end
		end
		rec.hs = hs_d;
	end

	assign q_push = has_res;
	assign q_rec  = rec;

endmodule

[hdl/ufl_queue.sv]
// ----------------------------------------------------------------------------
// ufl_queue
// Short record queue between the front and the back.
// ----------------------------------------------------------------------------
module ufl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ufl_pkg::rec_t wr_rec,
	input  logic          pop,
	output ufl_pkg::rec_t rd_rec,
	output logic          q_empty,
	output logic          q_full
);
	import ufl_pkg::*;

	rec_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QPTR_W:0]     count_q;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign rd_rec  = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

endmodule

[hdl/ufl_back.sv]
// ----------------------------------------------------------------------------
// ufl_back
// Expands each record into its one or two results and holds the oldest
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ufl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ufl_pkg::rec_t rec,
	input  logic          q_empty,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [1:0]    kind,
	output logic [7:0]    tx_byte,
	output logic [21:0]   flash_addr,
	output logic [15:0]   flash_data,
	output logic          erase_sector,
	output logic          handshake_seen,
	output logic          last
);
	import ufl_pkg::*;

	slot_t        slot_q, slot_d;
	logic         valid_q;
	logic         load;
	kind_t        sel_kind;
	logic         sel_last;

	assign load     = !q_empty && (!valid_q || pop);
	assign sel_kind = (slot_q == SLOT_SECOND) ? rec.kind1 : rec.kind0;
	assign sel_last = (slot_q == SLOT_SECOND) || !rec.two;

	// slot sequencing and queue pop
	always_comb begin
		slot_d = slot_q;
		q_pop  = 1'b0;
		case (slot_q)
			SLOT_FIRST: begin
				if (load) begin
					if (rec.two) begin
						slot_d = SLOT_SECOND;
					end else begin
						q_pop = 1'b1;
					end
				end
			end
			SLOT_SECOND: begin
				if (load) begin
					slot_d = SLOT_FIRST;
					q_pop  = 1'b1;
				end
			end
			default: slot_d = SLOT_FIRST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_FIRST;
			valid_q <= 1'b0;
		end else begin
			slot_q <= slot_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			kind           <= sel_kind;
			tx_byte        <= (slot_q == SLOT_SECOND) ? rec.tx1 : rec.tx0;
			flash_addr     <= (slot_q == SLOT_SECOND) ? '0 : rec.addr;
			flash_data     <= (slot_q == SLOT_SECOND) ? '0 : rec.data;
			erase_sector   <= (slot_q == SLOT_SECOND) && (rec.kind1 == KIND_ERASE);
			handshake_seen <= rec.hs;
			last           <= sel_last;
		end
	end

	assign empty = !valid_q;

endmodule

[hdl/uart_flash_loader_command_parser_top.sv]
// Items are written into the command queue on the accepting edge, and each result
// moves on into the output register when that register is empty or being popped.
// Throughput: one item per cycle while the four-entry queue has room; results leave
// at one per cycle while the result side pops, an item with two results giving two in turn.
// Reset (arst_n low, asynchronous): parser idle, queue and output empty,
// registers back to their default bases and page split.
// ----------------------------------------------------------------------------
// uart_flash_loader_command_parser_top
// Byte parser of a flash bootloader: configuration registers, front decode,
// command queue and result back end.
// ----------------------------------------------------------------------------
module uart_flash_loader_command_parser_top #(
	parameter int PAGE_BYTES = ufl_pkg::PAGE_BYTES_DEF,
	parameter int ADDR_BITS  = ufl_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// items
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	input  logic        erase_ok,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [21:0] flash_addr,
	output logic [15:0] flash_data,
	output logic        erase_sector,
	output logic        handshake_seen,
	output logic        last
);
	import ufl_pkg::*;

	cfg_t        cfg_q;
	logic        wr_en;
	logic [1:0]  reg_idx;
	logic        q_push;
	logic        q_pop;
	logic        q_empty;
	logic        q_full;
	rec_t        wr_rec;
	rec_t        rd_rec;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_base  <= LOW_BASE_RST;
			cfg_q.high_base <= HIGH_BASE_RST;
			cfg_q.split     <= SPLIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LOW_BASE:  cfg_q.low_base  <= pwdata[21:0];
				REG_HIGH_BASE: cfg_q.high_base <= pwdata[21:0];
				REG_SPLIT:     cfg_q.split     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_LOW_BASE:  prdata = {10'd0, cfg_q.low_base};
			REG_HIGH_BASE: prdata = {10'd0, cfg_q.high_base};
			REG_SPLIT:     prdata = {16'd0, cfg_q.split};
			default:       prdata = '0;
		endcase
	end

	assign full = q_full;

	ufl_front #(
		.PAGE_BYTES (PAGE_BYTES),
		.ADDR_BITS  (ADDR_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.opcode   (opcode),
		.rx_byte  (rx_byte),
		.erase_ok (erase_ok),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (wr_rec)
	);

	ufl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_rec  (wr_rec),
		.pop     (q_pop),
		.rd_rec  (rd_rec),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	ufl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec            (rd_rec),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.tx_byte        (tx_byte),
		.flash_addr     (flash_addr),
		.flash_data     (flash_data),
		.erase_sector   (erase_sector),
		.handshake_seen (handshake_seen),
		.last           (last)
	);

endmodule

[hdl/ufl_checker.sv]
// ----------------------------------------------------------------------------
// ufl_checker
// Port-level checks of the flash loader byte parser, bound to the top level.
// ----------------------------------------------------------------------------
module ufl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  kind,
	input logic [7:0]  tx_byte,
	input logic [21:0] flash_addr,
	input logic [15:0] flash_data,
	input logic        erase_sector,
	input logic        last
);
	import ufl_pkg::*;

	// nothing to deliver once reset has been applied
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result shown during reset");

	// a waiting result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(tx_byte)
			&& $stable(flash_addr) && $stable(flash_data) && $stable(last)))
		else $error("waiting result changed");

	// program words carry no byte and no sector
	a_prog_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_PROG) |-> (tx_byte == 8'd0 && erase_sector == 1'b0))
		else $error("program word with stray fields");

	// sector D request only as closing result of an erase status
	a_sector_d_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && erase_sector) |-> (kind == KIND_ERASE && last))
		else $error("sector D request misplaced");

	// jump is always the final result of its command
	a_jump_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_JUMP) |-> (last && flash_addr == 22'd0))
		else $error("jump not final");

endmodule

bind uart_flash_loader_command_parser_top ufl_checker u_ufl_checker (.*);

[test/uart_flash_loader_command_parser_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_flash_loader_command_parser_check
// Watches the item, result and configuration channels of the flash loader
// byte parser, predicts the results of every item transfer from its own copy
// of the parser state and registers, and compares each result transfer with
// the oldest prediction. Register reads are checked against the same copy.
// ----------------------------------------------------------------------------
module uart_flash_loader_command_parser_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	input  logic        erase_ok,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [7:0]  tx_byte,
	input  logic [21:0] flash_addr,
	input  logic [15:0] flash_data,
	input  logic        erase_sector,
	input  logic        handshake_seen,
	input  logic        last,
	output int          fail_count,
	output int          pending
);
	import ufl_pkg::*;

	localparam int PAGE_BYTES     = PAGE_BYTES_DEF;
	localparam int WORDS_PER_PAGE = PAGE_BYTES / 2;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx;
		logic [21:0] addr;
		logic [15:0] data;
		logic        sector;
		logic        hs;
		logic        last;
	} parser_out_t;

	parser_out_t expected_out[$];

	// register copy
	logic [21:0] low_base_q;
	logic [21:0] high_base_q;
	logic [15:0] split_q;

	// parser state copy
	logic [8:0]  byte_phase;
	logic [15:0] page_q;
	logic [7:0]  hold_q;
	erase_st_t   erase_q;
	logic        hs_q;

	initial fail_count = 0;

	function automatic parser_out_t make_out(input kind_t k, input logic [7:0] tx,
			input logic [21:0] a, input logic [15:0] d, input logic s);
		parser_out_t r;
		r.kind   = k;
		r.tx     = tx;
		r.addr   = a;
		r.data   = d;
		r.sector = s;
		r.hs     = 1'b0;
		r.last   = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] reg_value(input logic [1:0] idx);
		case (idx)
			REG_LOW_BASE:  return {10'd0, low_base_q};
			REG_HIGH_BASE: return {10'd0, high_base_q};
			REG_SPLIT:     return {16'd0, split_q};
			default:       return 32'd0;
		endcase
	endfunction

	// work out the results of one item and queue them
	task automatic predict_item(input logic op, input logic [7:0] b, input logic ok);
		parser_out_t res [2];
		int n;
		int idx;
		int i;
		logic [21:0] base;
		logic [31:0] sum;
		n = 0;
		if (op == OP_STATUS) begin
			if (erase_q == EW_SECT_E) begin
				res[0] = make_out(KIND_TX, ok ? RSP_ACK : RSP_FAIL, 22'd0, 16'd0, 1'b0);
				res[1] = make_out(KIND_ERASE, 8'd0, 22'd0, 16'd0, 1'b1);
				erase_q = EW_SECT_D;
				n = 2;
			end else if (erase_q == EW_SECT_D) begin
				res[0] = make_out(KIND_TX, ok ? RSP_ERASE_DONE : RSP_FAIL,
					22'd0, 16'd0, 1'b0);
				erase_q = EW_NONE;
				n = 1;
			end
		end else if (erase_q != EW_NONE) begin
			// byte dropped while an erase is waiting
		end else if (byte_phase == 9'd1) begin
			page_q = {8'd0, b};
			byte_phase = 9'd2;
		end else if (byte_phase == 9'd2) begin
			page_q = {page_q[7:0], b};
			byte_phase = 9'd3;
		end else if (byte_phase != 9'd0) begin
			// data byte: even index held, odd index completes a word
			idx = int'(byte_phase) - 3;
			if (int'(byte_phase) >= PAGE_BYTES + 2)
				byte_phase = 9'd0;
			else
				byte_phase = byte_phase + 9'd1;
			if (idx % 2 == 0) begin
				hold_q = b;
			end else begin
				base = (page_q <= split_q) ? low_base_q : high_base_q;
				sum = 32'(base) + 32'(page_q) * WORDS_PER_PAGE + 32'(idx / 2);
				res[0] = make_out(KIND_PROG, 8'd0, sum[21:0], {hold_q, b}, 1'b0);
				n = 1;
			end
		end else begin
			case (b)
				CMD_HANDSHAKE: begin
					hs_q = 1'b1;
					res[0] = make_out(KIND_TX, RSP_ACK, 22'd0, 16'd0, 1'b0);
					res[1] = make_out(KIND_TX, RSP_HANDSHAKE, 22'd0, 16'd0, 1'b0);
					n = 2;
				end
				CMD_ERASE: begin
					res[0] = make_out(KIND_ERASE, 8'd0, 22'd0, 16'd0, 1'b0);
					erase_q = EW_SECT_E;
					n = 1;
				end
				CMD_WRITE: begin
					byte_phase = 9'd1;
					res[0] = make_out(KIND_TX, RSP_ACK, 22'd0, 16'd0, 1'b0);
					res[1] = make_out(KIND_TX, RSP_WRITE, 22'd0, 16'd0, 1'b0);
					n = 2;
				end
				CMD_JUMP: begin
					res[0] = make_out(KIND_TX, RSP_ACK, 22'd0, 16'd0, 1'b0);
					res[1] = make_out(KIND_JUMP, 8'd0, 22'd0, 16'd0, 1'b0);
					n = 2;
				end
				default: ;
			endcase
		end
		for (i = 0; i < n; i++) begin
			res[i].hs = hs_q;
			res[i].last = (i == n - 1);
			expected_out.push_back(res[i]);
		end
	endtask

	// compare one result transfer with the oldest prediction
	task automatic check_result;
		parser_out_t got;
		parser_out_t want;
		got = {kind, tx_byte, flash_addr, flash_data, erase_sector, handshake_seen, last};
		if (expected_out.size() == 0) begin
			$display("%0t: result with nothing expected: kind=%0d tx=%h addr=%h data=%h",
				$time, got.kind, got.tx, got.addr, got.data);
			fail_count++;
		end else begin
			want = expected_out.pop_front();
			if (got !== want) begin
				$display("%0t: result mismatch, expected kind=%0d tx=%h addr=%h data=%h",
					$time, want.kind, want.tx, want.addr, want.data,
					" sector=%0d hs=%0d last=%0d", want.sector, want.hs, want.last);
				$display("%0t:                  actual kind=%0d tx=%h addr=%h data=%h",
					$time, got.kind, got.tx, got.addr, got.data,
					" sector=%0d hs=%0d last=%0d", got.sector, got.hs, got.last);
				fail_count++;
			end
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_base_q  = LOW_BASE_RST;
			high_base_q = HIGH_BASE_RST;
			split_q     = SPLIT_RST;
			byte_phase  = 9'd0;
			page_q      = 16'd0;
			hold_q      = 8'd0;
			erase_q     = EW_NONE;
			hs_q        = 1'b0;
			expected_out.delete();
			pending     = 0;
		end else begin
			// result transfer first: it always belongs to an older item
			if (pop && !empty)
				check_result();
			// register access
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_LOW_BASE:  low_base_q  = pwdata[21:0];
						REG_HIGH_BASE: high_base_q = pwdata[21:0];
						REG_SPLIT:     split_q     = pwdata[15:0];
						default: ;
					endcase
				end else if (prdata !== reg_value(paddr[3:2])) begin
					$display("%0t: register %0d read, expected %h actual %h",
						$time, paddr[3:2], reg_value(paddr[3:2]), prdata);
					fail_count++;
				end
			end
			// item transfer
			if (push && !full)
				predict_item(opcode, rx_byte, erase_ok);
			pending = expected_out.size();
		end
	end

endmodule

[test/uart_flash_loader_command_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_flash_loader_command_parser_top_test
// Stimulus for the flash loader byte parser: directed commands and erase
// flows, then random command, erase and page-write sequences under several
// register settings, with random gaps on both channels and one long stall of
// the result side. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module uart_flash_loader_command_parser_top_test;
	import ufl_pkg::*;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = 4'd0;
	logic [31:0] pwdata  = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        push     = 1'b0;
	logic        full;
	logic        opcode   = OP_BYTE;
	logic [7:0]  rx_byte  = 8'd0;
	logic        erase_ok = 1'b0;
	logic        empty;
	logic        pop      = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic [21:0] flash_addr;
	logic [15:0] flash_data;
	logic        erase_sector;
	logic        handshake_seen;
	logic        last;

	int fail_count;
	int pending;
	int send_idle_pct = 14;
	int recv_idle_pct = 14;
	bit stall_req     = 1'b0;
	int phase_items;
	logic [15:0] cur_split = SPLIT_RST;

	always #5 clk = ~clk;

	uart_flash_loader_command_parser_top DUT (.*);

	uart_flash_loader_command_parser_check checker_i (.*);

	// run limit
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random pops, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (stall_req) begin
				pop <= 1'b0;
				repeat (400) @(negedge clk);
				stall_req = 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one item transfer, with random gaps ahead of it
	task automatic send_item(input logic op, input logic [7:0] b, input logic ok);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push     <= 1'b1;
		opcode   <= op;
		rx_byte  <= b;
		erase_ok <= ok;
		@(posedge clk);
		while (full) @(posedge clk);
		phase_items++;
	endtask

	// wait until every predicted result has come, plus the pipeline depth
	task automatic drain;
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// register access: setup cycle, then access cycle until pready
	task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [21:0] lo, input logic [21:0] hi,
			input logic [15:0] sp);
		reg_access(1'b1, REG_LOW_BASE, {10'd0, lo});
		reg_access(1'b1, REG_HIGH_BASE, {10'd0, hi});
		reg_access(1'b1, REG_SPLIT, {16'd0, sp});
		reg_access(1'b0, REG_LOW_BASE, 32'd0);
		reg_access(1'b0, REG_HIGH_BASE, 32'd0);
		reg_access(1'b0, REG_SPLIT, 32'd0);
		cur_split = sp;
	endtask

	// page index, half of the picks around the split
	function automatic logic [15:0] pick_page;
		case ($urandom_range(5))
			0: return cur_split;
			1: return cur_split + 16'd1;
			2: return cur_split - 16'd1;
			3: return 16'd0;
			4: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// page index and data bytes after the write command, stray reports mixed in
	task automatic send_page_body(input logic [15:0] page);
		int i;
		send_item(OP_BYTE, page[15:8], 1'($urandom));
		send_item(OP_BYTE, page[7:0], 1'($urandom));
		for (i = 0; i < PAGE_BYTES_DEF; i++) begin
			if ($urandom_range(99) < 3)
				send_item(OP_STATUS, 8'($urandom), 1'($urandom));
			send_item(OP_BYTE, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic send_page;
		send_item(OP_BYTE, CMD_WRITE, 1'($urandom));
		send_page_body(pick_page());
	endtask

	// byte that the parser drops while an erase waits (anything goes)
	task automatic send_dropped_bytes(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_item(OP_BYTE, 8'($urandom), 1'($urandom));
	endtask

	// erase command, two status reports, dropped bytes between them
	task automatic send_erase_flow;
		send_item(OP_BYTE, CMD_ERASE, 1'($urandom));
		send_dropped_bytes($urandom_range(2));
		send_item(OP_STATUS, 8'($urandom), 1'($urandom));
		send_dropped_bytes($urandom_range(1));
		send_item(OP_STATUS, 8'($urandom), 1'($urandom));
		if ($urandom_range(99) < 20)
			send_item(OP_STATUS, 8'($urandom), 1'($urandom));
	endtask

	// random byte or report in idle; a write or erase it opens is completed
	task automatic send_noise;
		logic [7:0] b;
		if ($urandom_range(1) == 0) begin
			send_item(OP_STATUS, 8'($urandom), 1'($urandom));
		end else begin
			b = 8'($urandom);
			send_item(OP_BYTE, b, 1'($urandom));
			if (b == CMD_WRITE) begin
				send_page_body(pick_page());
			end else if (b == CMD_ERASE) begin
				send_item(OP_STATUS, 8'($urandom), 1'($urandom));
				send_item(OP_STATUS, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// optional full page first, then short commands until the budget is used
	task automatic run_random(input int budget, input bit with_page);
		int pick;
		phase_items = 0;
		if (with_page)
			send_page();
		while (phase_items < budget) begin
			pick = $urandom_range(99);
			if (pick < 20)
				send_item(OP_BYTE, CMD_HANDSHAKE, 1'($urandom));
			else if (pick < 38)
				send_item(OP_BYTE, CMD_JUMP, 1'($urandom));
			else if (pick < 70)
				send_erase_flow();
			else
				send_noise();
		end
		drain();
	endtask

	initial begin
		int wait_cycles;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers after reset
		reg_access(1'b0, REG_LOW_BASE, 32'd0);
		reg_access(1'b0, REG_HIGH_BASE, 32'd0);
		reg_access(1'b0, REG_SPLIT, 32'd0);

		// directed: stray reports, unknown bytes, each command (write only while an erase waits), both erase outcomes
		send_item(OP_STATUS, 8'h00, 1'b0);
		send_item(OP_STATUS, 8'hFF, 1'b1);
		send_item(OP_BYTE, 8'h00, 1'b0);
		send_item(OP_BYTE, 8'hFF, 1'b1);
		send_item(OP_BYTE, CMD_JUMP, 1'b0);
		send_item(OP_BYTE, CMD_HANDSHAKE, 1'b0);
		send_item(OP_BYTE, CMD_JUMP, 1'b1);
		send_item(OP_BYTE, CMD_ERASE, 1'b0);
		send_item(OP_BYTE, CMD_HANDSHAKE, 1'b0);
		send_item(OP_STATUS, 8'h00, 1'b1);
		send_item(OP_BYTE, CMD_WRITE, 1'b1);
		send_item(OP_STATUS, 8'hFF, 1'b0);
		send_item(OP_BYTE, CMD_ERASE, 1'b1);
		send_item(OP_STATUS, 8'hAA, 1'b0);
		send_item(OP_STATUS, 8'h55, 1'b1);
		send_item(OP_STATUS, 8'h00, 1'b1);
		drain();

		// reset registers, one page
		run_random(300, 1'b1);

		// low base zero, high base at the top, split zero; long result stall
		set_config(22'd0, 22'h3FFFFF, 16'd0);
		stall_req = 1'b1;
		run_random(60, 1'b0);

		// low base at the top, high base zero, split at the top
		set_config(22'h3FFFFF, 22'd0, 16'hFFFF);
		run_random(60, 1'b0);

		// random registers, one page, no gaps on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(22'($urandom), 22'($urandom), 16'($urandom));
		run_random(300, 1'b1);
		send_idle_pct = 14;
		recv_idle_pct = 14;

		// random registers, small split
		set_config(22'($urandom), 22'($urandom), 16'($urandom_range(300)));
		run_random(60, 1'b0);

		// final wait for stragglers
		for (wait_cycles = 0; pending != 0 && wait_cycles < 2000; wait_cycles++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (pending != 0)
			$display("%0t: %0d expected results never came", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
